// ===== design/ptt_pkg.sv =====
// Shared types, codes and constants for the push-to-talk capture controller.
package ptt_pkg;

	localparam int unsigned MS_PER_SECOND = 1000;

	localparam logic [15:0] SAMPLE_RATE_RST = 16'd16000;
	localparam logic [4:0]  MAX_SECONDS_RST = 5'd10;
	localparam logic [9:0]  DEBOUNCE_RST    = 10'd50;

	localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [1:0] REG_MAX_SECONDS = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE    = 2'd2;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_KEY    = 2'd1;
	localparam logic [1:0] MODE_SAMPLE = 2'd2;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_STARTED  = 3'd1;
	localparam logic [2:0] EV_STOP_KEY = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_FULL     = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic               key_pressed;
		logic signed [15:0] sample;
	} ptt_item_t;

	typedef struct packed {
		logic               listening;
		logic [2:0]         event_res;
		logic               write_valid;
		logic [20:0]        write_addr;
		logic signed [15:0] write_data;
		logic [20:0]        fill_count;
		logic [15:0]        peak_level;
		logic [31:0]        elapsed;
		logic [31:0]        last_duration;
		logic [15:0]        last_peak;
		logic [20:0]        last_frames;
	} ptt_result_t;

endpackage

// ===== design/push_to_talk_capture_control_top.sv =====
// Push-to-talk capture controller: key debounce, capture timing and sample write control.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-------------------
//  item     | item_valid / item_stall          | ptt_item_t
//  result   | result_valid / result_stall      | ptt_result_t
//  config   | psel penable pwrite pready (APB) | paddr pwdata prdata
//
// One beat per cycle unless the result stalls: an item is registered, the control
// state is updated by one pass of compare/update logic, and the result lands in an
// output register; result_valid rises when that register is loaded.
// Reset clears all control state and loads the register defaults.
// A stalled result holds; one more item may wait in the input register meanwhile.
module push_to_talk_capture_control_top
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  ptt_item_t   item,
	output logic        result_valid,
	input  logic        result_stall,
	output ptt_result_t result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	function automatic logic diff_at_least(logic [31:0] later, logic [31:0] earlier,
		logic [31:0] bound);
		logic [31:0] d;
		d = later - earlier;
		return !d[31] && (d >= bound);
	endfunction

	logic [15:0] sample_rate_q;
	logic [4:0]  max_seconds_q;
	logic [9:0]  debounce_q;

	logic        valid_s1;
	ptt_item_t   item_s1;
	logic        advance;

	logic [31:0] clock_q, last_edge_q, start_q, dur_q;
	logic        key_prev_q, active_q;
	logic [20:0] fill_q, dframes_q;
	logic [15:0] peak_q, dpeak_q;

	logic [31:0] clock_n, last_edge_n, start_n, dur_n;
	logic        key_prev_n, active_n;
	logic [20:0] fill_n, dframes_n;
	logic [15:0] peak_n, dpeak_n;

	logic [2:0]  ev;
	logic        wv;
	logic [20:0] wa;
	logic [15:0] wd;

	logic [5:0]  secs_plus1;
	logic [20:0] capacity;
	logic [14:0] limit_ms;
	logic [15:0] mag;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= SAMPLE_RATE_RST;
			max_seconds_q <= MAX_SECONDS_RST;
			debounce_q    <= DEBOUNCE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SAMPLE_RATE: sample_rate_q <= pwdata[15:0];
				REG_MAX_SECONDS: max_seconds_q <= pwdata[4:0];
				REG_DEBOUNCE:    debounce_q    <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SAMPLE_RATE: prdata = {16'd0, sample_rate_q};
			REG_MAX_SECONDS: prdata = {27'd0, max_seconds_q};
			REG_DEBOUNCE:    prdata = {22'd0, debounce_q};
			default:         prdata = 32'd0;
		endcase
	end

	// handshake
	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// derived limits; the largest capacity still fits 21 bits
	assign secs_plus1 = {1'b0, max_seconds_q} + 6'd1;
	assign capacity   = 21'(sample_rate_q) * 21'(secs_plus1);
	assign limit_ms   = 15'(max_seconds_q) * 15'(MS_PER_SECOND);
	assign mag        = item_s1.sample[15] ? (~item_s1.sample + 16'd1) : item_s1.sample;

	always_comb begin
		clock_n     = clock_q;
		last_edge_n = last_edge_q;
		start_n     = start_q;
		dur_n       = dur_q;
		key_prev_n  = key_prev_q;
		active_n    = active_q;
		fill_n      = fill_q;
		dframes_n   = dframes_q;
		peak_n      = peak_q;
		dpeak_n     = dpeak_q;
		ev          = EV_NONE;
		wv          = 1'b0;
		wa          = 21'd0;
		wd          = 16'd0;
		case (item_s1.mode)
			MODE_TICK: begin
				clock_n = clock_q + 32'd1;
			end
			MODE_KEY: begin
				if (item_s1.key_pressed && !key_prev_q &&
					diff_at_least(clock_q, last_edge_q, {22'd0, debounce_q})) begin
					last_edge_n = clock_q;
					if (active_q) begin
						active_n  = 1'b0;
						dur_n     = clock_q - start_q;
						dpeak_n   = peak_q;
						dframes_n = fill_q;
						ev        = EV_STOP_KEY;
					end else begin
						fill_n    = 21'd0;
						peak_n    = 16'd0;
						start_n   = clock_q;
						dframes_n = 21'd0;
						active_n  = 1'b1;
						ev        = EV_STARTED;
					end
				end
				key_prev_n = item_s1.key_pressed;
				if (active_n && diff_at_least(clock_q, start_n, {17'd0, limit_ms})) begin
					active_n  = 1'b0;
					dur_n     = clock_q - start_n;
					dpeak_n   = peak_n;
					dframes_n = fill_n;
					ev        = EV_TIMEOUT;
				end
			end
			MODE_SAMPLE: begin
				if (active_q) begin
					if (fill_q < capacity) begin
						wv = 1'b1;
						wa = fill_q;
						wd = item_s1.sample;
						if (mag > peak_q) begin
							peak_n = mag;
						end
						fill_n = fill_q + 21'd1;
					end
					if (fill_n >= capacity) begin
						active_n  = 1'b0;
						dur_n     = clock_q - start_q;
						dpeak_n   = peak_n;
						dframes_n = fill_n;
						ev        = EV_FULL;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= 32'd0;
			last_edge_q <= 32'd0;
			start_q     <= 32'd0;
			dur_q       <= 32'd0;
			key_prev_q  <= 1'b0;
			active_q    <= 1'b0;
			fill_q      <= 21'd0;
			dframes_q   <= 21'd0;
			peak_q      <= 16'd0;
			dpeak_q     <= 16'd0;
		end else if (advance) begin
			clock_q     <= clock_n;
			last_edge_q <= last_edge_n;
			start_q     <= start_n;
			dur_q       <= dur_n;
			key_prev_q  <= key_prev_n;
			active_q    <= active_n;
			fill_q      <= fill_n;
			dframes_q   <= dframes_n;
			peak_q      <= peak_n;
			dpeak_q     <= dpeak_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.listening     <= active_n;
			result.event_res     <= ev;
			result.write_valid   <= wv;
			result.write_addr    <= wa;
			result.write_data    <= wd;
			result.fill_count    <= fill_n;
			result.peak_level    <= peak_n;
			result.elapsed       <= active_n ? (clock_n - start_n) : 32'd0;
			result.last_duration <= dur_n;
			result.last_peak     <= dpeak_n;
			result.last_frames   <= dframes_n;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the push-to-talk capture controller: predicts every result beat and checks it.
`timescale 1ns / 100ps

import ptt_pkg::*;

class take_tracker;
	logic [15:0] rate;
	logic [4:0]  max_sec;
	logic [9:0]  debounce;
	logic [31:0] clock_ms;
	logic [31:0] last_edge;
	logic [31:0] start_time;
	logic [31:0] done_duration;
	logic        key_prev;
	logic        active;
	logic [20:0] fill;
	logic [20:0] done_frames;
	logic [15:0] peak;
	logic [15:0] done_peak;
	ptt_result_t status_due[$];
	int          mismatches;

	function new();
		rate = SAMPLE_RATE_RST;
		max_sec = MAX_SECONDS_RST;
		debounce = DEBOUNCE_RST;
		clock_ms = '0;
		last_edge = '0;
		start_time = '0;
		done_duration = '0;
		key_prev = 1'b0;
		active = 1'b0;
		fill = '0;
		done_frames = '0;
		peak = '0;
		done_peak = '0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] value);
		case (idx)
			REG_SAMPLE_RATE: rate = value[15:0];
			REG_MAX_SECONDS: max_sec = value[4:0];
			REG_DEBOUNCE: debounce = value[9:0];
			default: ;
		endcase
	endfunction

	// modular difference read as signed, then compared to the bound
	function bit reached(logic [31:0] later, logic [31:0] earlier, logic [31:0] bound);
		logic [31:0] d;
		d = later - earlier;
		return !d[31] && d >= bound;
	endfunction

	function void start_take();
		fill = '0;
		peak = '0;
		start_time = clock_ms;
		done_frames = '0;
		active = 1'b1;
	endfunction

	function void stop_take();
		active = 1'b0;
		done_duration = clock_ms - start_time;
		done_peak = peak;
		done_frames = fill;
	endfunction

	function void note_item(ptt_item_t it);
		ptt_result_t r;
		logic [31:0] capacity;
		logic [16:0] mag;
		r = '0;
		case (it.mode)
			MODE_TICK: clock_ms = clock_ms + 32'd1;
			MODE_KEY: begin
				if (it.key_pressed && !key_prev &&
						reached(clock_ms, last_edge, 32'(debounce))) begin
					last_edge = clock_ms;
					if (active) begin
						stop_take();
						r.event_res = EV_STOP_KEY;
					end else begin
						start_take();
						r.event_res = EV_STARTED;
					end
				end
				key_prev = it.key_pressed;
				if (active && reached(clock_ms, start_time, 32'(max_sec) * MS_PER_SECOND)) begin
					stop_take();
					r.event_res = EV_TIMEOUT;
				end
			end
			MODE_SAMPLE: begin
				if (active) begin
					capacity = 32'(rate) * (32'(max_sec) + 32'd1);
					if ({11'd0, fill} < capacity) begin
						mag = it.sample[15] ? 17'h10000 - {1'b0, it.sample} : {1'b0, it.sample};
						r.write_valid = 1'b1;
						r.write_addr = fill;
						r.write_data = it.sample;
						if (mag > {1'b0, peak})
							peak = mag[15:0];
						fill = fill + 21'd1;
					end
					if ({11'd0, fill} >= capacity) begin
						stop_take();
						r.event_res = EV_FULL;
					end
				end
			end
			default: ;
		endcase
		r.listening = active;
		r.fill_count = fill;
		r.peak_level = peak;
		r.elapsed = active ? clock_ms - start_time : 32'd0;
		r.last_duration = done_duration;
		r.last_peak = done_peak;
		r.last_frames = done_frames;
		status_due.push_back(r);
	endfunction

	function void compare(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%s mismatch: expected %0h, got %0h", name, want, seen);
		end
	endfunction

	function void check_status(ptt_result_t got);
		ptt_result_t want;
		if (status_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result beat with no item pending: %h", got);
			return;
		end
		want = status_due.pop_front();
		compare("listening", want.listening, got.listening);
		compare("event_res", want.event_res, got.event_res);
		compare("write_valid", want.write_valid, got.write_valid);
		compare("write_addr", want.write_addr, got.write_addr);
		compare("write_data", want.write_data, got.write_data);
		compare("fill_count", want.fill_count, got.fill_count);
		compare("peak_level", want.peak_level, got.peak_level);
		compare("elapsed", want.elapsed, got.elapsed);
		compare("last_duration", want.last_duration, got.last_duration);
		compare("last_peak", want.last_peak, got.last_peak);
		compare("last_frames", want.last_frames, got.last_frames);
	endfunction
endclass

module tb_top;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	ptt_item_t   item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	ptt_result_t result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	take_tracker book = new();
	int send_idle = 0;
	int recv_stall = 0;
	int items_sent = 0;

	push_to_talk_capture_control_top u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			book.check_status(result);
		result_stall <= recv_stall != 0 && $urandom_range(99) < recv_stall;
	end

	initial begin
		#2_000_000;
		$display("** push_to_talk_capture_control_top: FAILED **");
		$finish;
	end

	task send_item(logic [1:0] mode, logic key, logic [15:0] smp);
		ptt_item_t it;
		it.mode = mode;
		it.key_pressed = key;
		it.sample = smp;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		book.note_item(it);
		if (mode != MODE_UNUSED)
			items_sent++;
	endtask

	task send_ticks(int n);
		repeat (n) send_item(MODE_TICK, 1'b0, 16'd0);
	endtask

	function logic [15:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// hold the sender until every beat in flight has come back
	task drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (book.status_due.size() != 0);
	endtask

	// psel stays high between back-to-back writes; configure releases the bus
	task apb_write(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_reg(idx, value);
	endtask

	task configure(logic [15:0] r, logic [4:0] m, logic [9:0] d);
		drain();
		repeat (4) @(posedge clk);
		apb_write(REG_SAMPLE_RATE, {16'd0, r});
		apb_write(REG_MAX_SECONDS, {27'd0, m});
		apb_write(REG_DEBOUNCE, {22'd0, d});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// press, capture a burst, optionally press again to close the take
	task run_take(int deb, bit close);
		int n;
		send_ticks(deb);
		send_item(MODE_KEY, 1'b0, 16'($urandom));
		send_item(MODE_KEY, 1'b1, 16'($urandom));
		n = $urandom_range(12, 1);
		repeat (n) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4: send_ticks($urandom_range(3, 1));
				5, 6, 7: send_item(MODE_KEY, 1'b1, 16'($urandom));
				default: send_item(MODE_SAMPLE, 1'($urandom), rand_sample());
			endcase
		end
		if (close) begin
			send_ticks(deb);
			send_item(MODE_KEY, 1'b0, 16'($urandom));
			send_item(MODE_KEY, 1'b1, 16'($urandom));
		end
	endtask

	task run_phase(logic [15:0] r, logic [4:0] m, logic [9:0] d, int idle, int target);
		int stop_at;
		configure(r, m, d);
		case (idle)
			1: begin
				send_idle = 56;
				recv_stall = 0;
			end
			2: begin
				send_idle = 0;
				recv_stall = 56;
			end
			3: begin
				send_idle = 30;
				recv_stall = 30;
			end
			default: begin
				send_idle = 0;
				recv_stall = 0;
			end
		endcase
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 70)
				run_take(d, $urandom_range(3) != 0);
			else
				send_item(2'($urandom_range(3)), 1'($urandom), 16'($urandom));
			if ($urandom_range(149) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'd1, 5'd1, 10'd2);
		send_item(MODE_UNUSED, 1'b1, 16'hFFFF);
		send_item(MODE_SAMPLE, 1'b0, 16'h7FFF);
		send_item(MODE_KEY, 1'b1, 16'h0000);
		send_ticks(2);
		send_item(MODE_KEY, 1'b1, 16'h0000);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_item(MODE_KEY, 1'b1, 16'h0000);
		send_item(MODE_SAMPLE, 1'b0, 16'hFFFF);
		send_item(MODE_SAMPLE, 1'b1, 16'h8000);
		send_item(MODE_SAMPLE, 1'b0, 16'h0001);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_ticks(2);
		send_item(MODE_KEY, 1'b1, 16'h0000);
		send_ticks(1);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_item(MODE_KEY, 1'b1, 16'h0000);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_ticks(1);
		send_item(MODE_KEY, 1'b1, 16'h0000);

		// zero time limit: start and timeout on one poll
		configure(16'd0, 5'd0, 10'd2);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_ticks(2);
		send_item(MODE_KEY, 1'b1, 16'h0000);

		// zero capacity: first sample ends the take
		configure(16'd0, 5'd5, 10'd0);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_item(MODE_KEY, 1'b1, 16'h0000);
		send_item(MODE_SAMPLE, 1'b0, 16'h1234);

		// real timeout by ticks
		configure(16'd8000, 5'd1, 10'd0);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_item(MODE_KEY, 1'b1, 16'h0000);
		repeat (5) send_item(MODE_SAMPLE, 1'b0, rand_sample());
		send_ticks(1000);
		send_item(MODE_KEY, 1'b0, 16'h0000);

		// longest debounce: press taken right at the bound, quick repeat ignored
		configure(16'd8000, 5'd1, 10'd1023);
		send_ticks(23);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_item(MODE_KEY, 1'b1, 16'h0000);
		send_item(MODE_KEY, 1'b0, 16'h0000);
		send_item(MODE_KEY, 1'b1, 16'h0000);

		run_phase(16'd3, 5'd1, 10'd0, 0, 90);
		run_phase(16'd1, 5'd0, 10'd3, 1, 70);
		run_phase(16'd0, 5'd31, 10'd1, 2, 70);
		run_phase(16'd65535, 5'd31, 10'd0, 3, 90);
		run_phase(16'd5, 5'd2, 10'd2, 1, 90);
		run_phase(SAMPLE_RATE_RST, MAX_SECONDS_RST, DEBOUNCE_RST, 2, 110);
		run_phase(16'd2, 5'd3, 10'd0, 3, 90);
		run_phase(16'd4, 5'd1, 10'd1, 0, 70);

		drain();
		repeat (8) @(posedge clk);
		if (book.mismatches == 0 && book.status_due.size() == 0)
			$display("** push_to_talk_capture_control_top: PASSED **");
		else
			$display("** push_to_talk_capture_control_top: FAILED **");
		$finish;
	end
endmodule

// ===== sim.f =====
design/ptt_pkg.sv
design/push_to_talk_capture_control_top.sv
dv/tb_top.sv
